// ===== rtl/core/fhm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fhm_pkg;

  // matrix and store geometry; the store depth is a power of two
  localparam int unsigned MaxWidth   = 32;
  localparam int unsigned MaxHeight  = 32;
  localparam int unsigned StoreDepth = 1024;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  localparam int unsigned EffWW = $clog2(MaxWidth + 1);
  localparam int unsigned EffHW = $clog2(MaxHeight + 1);
  localparam int unsigned IdxW  = $clog2(StoreDepth);

  // fixed field widths
  localparam int unsigned CfgW  = 6;
  localparam int unsigned CoolW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned HeatW = 8;
  localparam int unsigned PixW  = 10;

  // width of the raster index sum, wide enough for every consumer
  localparam int unsigned PixRawW = RowW + EffWW + 1;
  localparam int unsigned PixMaxA = (PixRawW > PixW) ? PixRawW : PixW;
  localparam int unsigned PixFullW = (PixMaxA > IdxW) ? PixMaxA : IdxW;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  // fire constants
  localparam logic [HeatW-1:0] CoolFloor   = 8'd20;
  localparam logic [HeatW-1:0] CoolStep    = 8'd5;
  localparam logic [ByteW-1:0] IgniteLimit = 8'd150;
  localparam logic [HeatW-1:0] IgniteBase  = 8'd180;
  localparam logic [ByteW-1:0] IgniteMask  = 8'd75;
  localparam logic [HeatW-1:0] RampLow     = 8'd85;
  localparam logic [HeatW-1:0] RampHigh    = 8'd170;
  localparam logic [ByteW-1:0] ChanFull    = 8'hFF;

  // divide by three: (v * 683) >> 11 is exact for v up to 765
  localparam int unsigned Div3InW  = HeatW + 2;
  localparam int unsigned Div3ProdW = 2 * Div3InW;
  localparam logic [Div3InW-1:0] Div3Mul = 10'd683;
  localparam int unsigned Div3Shift = 11;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// ===== rtl/core/fhm_heat_ramp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fhm_heat_ramp (
  input  wire logic [fhm_pkg::HeatW-1:0] heat_i,
  output fhm_pkg::rgb_t                  rgb_o
);

  logic [fhm_pkg::HeatW-1:0]   span;
  logic [fhm_pkg::HeatW+1:0]   span_x3;

  always_comb begin
    if (heat_i < fhm_pkg::RampLow) begin
      span = heat_i;
    end else if (heat_i < fhm_pkg::RampHigh) begin
      span = heat_i - fhm_pkg::RampLow;
    end else begin
      span = heat_i - fhm_pkg::RampHigh;
    end
    // 3 * span as shift and add
    span_x3 = {1'b0, span, 1'b0} + {2'b00, span};
  end

  always_comb begin
    rgb_o = '0;
    if (heat_i < fhm_pkg::RampLow) begin
      rgb_o.red = span_x3[fhm_pkg::ByteW-1:0];
    end else if (heat_i < fhm_pkg::RampHigh) begin
      rgb_o.red   = fhm_pkg::ChanFull;
      rgb_o.green = span_x3[fhm_pkg::ByteW-1:0];
    end else begin
      rgb_o.red   = fhm_pkg::ChanFull;
      rgb_o.green = fhm_pkg::ChanFull;
      rgb_o.blue  = span_x3[fhm_pkg::ByteW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fire_heat_map_pixel_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fire effect pixel engine: takes one item per cell in raster order (x fastest,
// row 0 first) carrying the random draws for that cell, and returns one item
// with the cell's raster index, new heat and heat color. It sustains one cell
// per clock while the output is taken; results pass from stage 1 to the output
// register, and a two-entry path (pipeline stage plus output register) keeps
// input flowing while the output waits. The heat store is one 1024-entry
// synchronous memory read and written back each cell, with the two cooled-row
// line buffers as small memories beside it; writes land as a cell leaves
// stage 1, possibly as the next cell is read, so a cell that hits the entry
// written by the cell just before it (a one-cell frame, or a one-column frame
// for the line buffers) is served by forwarding. After reset the heat store is
// cleared one entry per cycle, and no cell is accepted until the clearing ends;
// configuration writes are taken at all times and are meant to happen only
// while the engine is idle. Width and height of 0 or above 32 mean 32.

module fire_heat_map_pixel_engine_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [fhm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [fhm_pkg::CfgW-1:0]       cfg_data_i,

  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [fhm_pkg::CoolW-1:0]      cool_amount_i,
  input  wire logic [fhm_pkg::ByteW-1:0]      ignite_roll_i,
  input  wire logic [fhm_pkg::ByteW-1:0]      ignite_boost_i,

  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [fhm_pkg::PixW-1:0]       pixel_index_o,
  output      logic [fhm_pkg::ByteW-1:0]      red_o,
  output      logic [fhm_pkg::ByteW-1:0]      green_o,
  output      logic [fhm_pkg::ByteW-1:0]      blue_o,
  output      logic [fhm_pkg::HeatW-1:0]      heat_level_o,
  output      logic                           frame_done_o
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [fhm_pkg::CfgW-1:0] frame_width_q, frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= fhm_pkg::CfgW'(fhm_pkg::MaxWidth);
      frame_height_q <= fhm_pkg::CfgW'(fhm_pkg::MaxHeight);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fhm_pkg::CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        fhm_pkg::CfgFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective size: zero or above the maximum saturates at the maximum
  logic [fhm_pkg::EffWW-1:0] w_eff;
  logic [fhm_pkg::EffHW-1:0] h_eff;

  always_comb begin
    if (frame_width_q == '0 || int'(frame_width_q) > fhm_pkg::MaxWidth) begin
      w_eff = fhm_pkg::EffWW'(fhm_pkg::MaxWidth);
    end else begin
      w_eff = fhm_pkg::EffWW'(frame_width_q);
    end
    if (frame_height_q == '0 || int'(frame_height_q) > fhm_pkg::MaxHeight) begin
      h_eff = fhm_pkg::EffHW'(fhm_pkg::MaxHeight);
    end else begin
      h_eff = fhm_pkg::EffHW'(frame_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // reset clearing pass over the heat store
  // ---------------------------------------------------------------------------
  logic                     clr_active_q;
  logic [fhm_pkg::IdxW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == fhm_pkg::IdxW'(fhm_pkg::StoreDepth - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic in_accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !clr_active_q && (!s1_valid_q || out_free);
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // stage 0: cursors, raster index, memory reads
  // ---------------------------------------------------------------------------
  logic [fhm_pkg::ColW-1:0]     col_q, col_d;
  logic [fhm_pkg::RowW-1:0]     row_q, row_d;
  logic [fhm_pkg::ColW-1:0]     cur_x;
  logic [fhm_pkg::RowW-1:0]     cur_y;
  logic [fhm_pkg::EffHW-1:0]    row_step;
  logic [fhm_pkg::EffWW-1:0]    x_inc;
  logic [fhm_pkg::EffHW-1:0]    y_inc;
  logic                         last_col, last_row;
  logic [fhm_pkg::PixFullW-1:0] pix_full;
  logic [fhm_pkg::IdxW-1:0]     cur_idx;

  always_comb begin
    // wrap a cursor left beyond a size that shrank
    if (fhm_pkg::EffWW'(col_q) >= w_eff) begin
      cur_x    = '0;
      row_step = fhm_pkg::EffHW'(row_q) + 1'b1;
    end else begin
      cur_x    = col_q;
      row_step = fhm_pkg::EffHW'(row_q);
    end
    if (row_step >= h_eff) begin
      cur_y = '0;
    end else begin
      cur_y = row_step[fhm_pkg::RowW-1:0];
    end

    pix_full = fhm_pkg::PixFullW'(cur_y) * fhm_pkg::PixFullW'(w_eff)
             + fhm_pkg::PixFullW'(cur_x);
    cur_idx  = pix_full[fhm_pkg::IdxW-1:0];

    x_inc    = fhm_pkg::EffWW'(cur_x) + 1'b1;
    y_inc    = fhm_pkg::EffHW'(cur_y) + 1'b1;
    last_col = (x_inc >= w_eff);
    last_row = (y_inc >= h_eff);

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : y_inc[fhm_pkg::RowW-1:0];
    end else begin
      col_d = x_inc[fhm_pkg::ColW-1:0];
      row_d = cur_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 registers
  // ---------------------------------------------------------------------------
  logic [fhm_pkg::IdxW-1:0]  s1_idx_q;
  logic [fhm_pkg::ColW-1:0]  s1_x_q;
  logic                      s1_row0_q, s1_row1_q;
  logic [fhm_pkg::PixW-1:0]  s1_pix_q;
  logic                      s1_done_q;
  logic [fhm_pkg::CoolW-1:0] s1_cool_q;
  logic                      s1_ignite_q;
  logic [fhm_pkg::HeatW-1:0] s1_boost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q    <= cur_idx;
      s1_x_q      <= cur_x;
      s1_row0_q   <= (cur_y == fhm_pkg::RowW'(0));
      s1_row1_q   <= (cur_y == fhm_pkg::RowW'(1));
      s1_pix_q    <= pix_full[fhm_pkg::PixW-1:0];
      s1_done_q   <= last_col && last_row;
      s1_cool_q   <= cool_amount_i;
      s1_ignite_q <= (ignite_roll_i < fhm_pkg::IgniteLimit);
      s1_boost_q  <= fhm_pkg::HeatW'(ignite_boost_i & fhm_pkg::IgniteMask);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 compute: cool, blend rows, ignite
  // ---------------------------------------------------------------------------
  logic [fhm_pkg::HeatW-1:0]     heat_rd_q, above_rd_q, two_rd_q;
  logic                          heat_fwd_q, line_fwd_q;
  logic [fhm_pkg::HeatW-1:0]     heat_fwd_data_q, above_fwd_data_q, two_fwd_data_q;
  logic [fhm_pkg::HeatW-1:0]     old_heat, cooled, c1, c2, blend, new_heat;
  logic [fhm_pkg::Div3InW-1:0]   blend_sum;
  logic [fhm_pkg::Div3ProdW-1:0] blend_prod;

  always_comb begin
    old_heat = heat_fwd_q ? heat_fwd_data_q : heat_rd_q;
    c1       = line_fwd_q ? above_fwd_data_q : above_rd_q;
    c2       = line_fwd_q ? two_fwd_data_q : two_rd_q;

    if (old_heat > fhm_pkg::CoolFloor) begin
      cooled = old_heat - fhm_pkg::HeatW'(s1_cool_q) - fhm_pkg::CoolStep;
    end else begin
      cooled = '0;
    end

    // (c1 + 2*c2) / 3 through the reciprocal
    blend_sum  = fhm_pkg::Div3InW'(c1) + {1'b0, c2, 1'b0};
    blend_prod = fhm_pkg::Div3ProdW'(blend_sum) * fhm_pkg::Div3ProdW'(fhm_pkg::Div3Mul);
    blend      = blend_prod[fhm_pkg::Div3Shift +: fhm_pkg::HeatW];

    if (s1_row0_q) begin
      new_heat = s1_ignite_q ? (fhm_pkg::IgniteBase + s1_boost_q) : cooled;
    end else if (s1_row1_q) begin
      new_heat = cooled;
    end else begin
      new_heat = blend;
    end
  end

  // ---------------------------------------------------------------------------
  // memories: read at accept, written back when stage 1 moves on
  // ---------------------------------------------------------------------------
  logic [fhm_pkg::HeatW-1:0] heat_mem  [fhm_pkg::StoreDepth];
  logic [fhm_pkg::HeatW-1:0] above_mem [fhm_pkg::MaxWidth];
  logic [fhm_pkg::HeatW-1:0] two_mem   [fhm_pkg::MaxWidth];

  logic                      heat_we;
  logic [fhm_pkg::IdxW-1:0]  heat_waddr;
  logic [fhm_pkg::HeatW-1:0] heat_wdata;

  always_comb begin
    if (clr_active_q) begin
      heat_we    = 1'b1;
      heat_waddr = clr_addr_q;
      heat_wdata = '0;
    end else begin
      heat_we    = s1_adv;
      heat_waddr = s1_idx_q;
      heat_wdata = new_heat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (heat_we) begin
      heat_mem[heat_waddr] <= heat_wdata;
    end
    if (in_accept) begin
      heat_rd_q <= heat_mem[cur_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      above_mem[s1_x_q] <= cooled;
      two_mem[s1_x_q]   <= c1;
    end
    if (in_accept) begin
      above_rd_q <= above_mem[cur_x];
      two_rd_q   <= two_mem[cur_x];
    end
  end

  // forwarding of a write that lands in the same cycle as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_fwd_q <= 1'b0;
      line_fwd_q <= 1'b0;
    end else if (in_accept) begin
      heat_fwd_q <= s1_adv && (s1_idx_q == cur_idx);
      line_fwd_q <= s1_adv && (s1_x_q == cur_x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      heat_fwd_data_q  <= new_heat;
      above_fwd_data_q <= cooled;
      two_fwd_data_q   <= c1;
    end
  end

  // ---------------------------------------------------------------------------
  // output register and color ramp
  // ---------------------------------------------------------------------------
  logic [fhm_pkg::PixW-1:0]  out_pix_q;
  logic [fhm_pkg::HeatW-1:0] out_heat_q;
  logic                      out_done_q;
  fhm_pkg::rgb_t             out_rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pix_q  <= s1_pix_q;
      out_heat_q <= new_heat;
      out_done_q <= s1_done_q;
    end
  end

  fhm_heat_ramp u_ramp (
    .heat_i (out_heat_q),
    .rgb_o  (out_rgb)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_pix_q;
  assign heat_level_o  = out_heat_q;
  assign frame_done_o  = out_done_q;
  assign red_o         = out_rgb.red;
  assign green_o       = out_rgb.green;
  assign blue_o        = out_rgb.blue;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_active_q |-> !in_ready_o
  ) else $error("cell accepted during heat store clearing");

  a_clear_runs_once : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !clr_active_q |=> !clr_active_q
  ) else $error("clearing pass restarted");

  a_stage1_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_idx_q) && $stable(s1_pix_q))
  ) else $error("stalled cell lost or changed in stage 1");

  a_full_blocks_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o
  ) else $error("cell accepted with both stages full");

endmodule

`default_nettype wire

// ===== tb/tb_fire_heat_map_pixel_engine_top.sv =====
`timescale 1ns / 1ps

module tb_fire_heat_map_pixel_engine_top;

  // one expected pixel item
  typedef struct {
    logic [fhm_pkg::PixW-1:0]  pix;
    fhm_pkg::rgb_t             color;
    logic [fhm_pkg::HeatW-1:0] heat;
    logic                      done;
  } pixel_item_t;

  // fire predictor plus the queue of pixels still owed by the engine
  class fire_pixel_checker;
    logic [fhm_pkg::HeatW-1:0] heat_mem [fhm_pkg::StoreDepth];
    logic [fhm_pkg::HeatW-1:0] cooled_prev [fhm_pkg::MaxWidth];
    logic [fhm_pkg::HeatW-1:0] cooled_prev2 [fhm_pkg::MaxWidth];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [fhm_pkg::CfgW-1:0]  width_reg;
    logic [fhm_pkg::CfgW-1:0]  height_reg;
    pixel_item_t               pending_pixels [$];
    int unsigned               mismatch_count;
    int unsigned               pixel_count;
    int unsigned               frame_count;

    function new();
      foreach (heat_mem[i]) heat_mem[i] = '0;
      foreach (cooled_prev[i]) begin
        cooled_prev[i]  = '0;
        cooled_prev2[i] = '0;
      end
      col_pos        = 0;
      row_pos        = 0;
      width_reg      = fhm_pkg::CfgW'(fhm_pkg::MaxWidth);
      height_reg     = fhm_pkg::CfgW'(fhm_pkg::MaxHeight);
      mismatch_count = 0;
      pixel_count    = 0;
      frame_count    = 0;
    endfunction

    function int unsigned eff_size(logic [fhm_pkg::CfgW-1:0] v, int unsigned lim);
      return (v == 0 || v > lim) ? lim : int'(v);
    endfunction

    function void set_reg(logic [fhm_pkg::CfgIdxW-1:0] idx,
                          logic [fhm_pkg::CfgW-1:0] val);
      if (idx == fhm_pkg::CfgFrameWidth) width_reg = val;
      else if (idx == fhm_pkg::CfgFrameHeight) height_reg = val;
    endfunction

    function void note_cell(logic [fhm_pkg::CoolW-1:0] cool,
                            logic [fhm_pkg::ByteW-1:0] roll,
                            logic [fhm_pkg::ByteW-1:0] boost);
      int unsigned w, h, x, y, idx, old, cooled, nh;
      pixel_item_t p;
      w = eff_size(width_reg, fhm_pkg::MaxWidth);
      h = eff_size(height_reg, fhm_pkg::MaxHeight);
      // cursors kept across a size change, wrapped into the new frame
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      idx = (y * w + x) % fhm_pkg::StoreDepth;
      old = heat_mem[idx];
      cooled = (old > fhm_pkg::CoolFloor) ? old - cool - fhm_pkg::CoolStep : 0;
      if (y == 0) begin
        nh = (roll < fhm_pkg::IgniteLimit) ?
             fhm_pkg::IgniteBase + (boost & fhm_pkg::IgniteMask) : cooled;
      end else if (y == 1) begin
        nh = cooled;
      end else begin
        nh = (cooled_prev[x] + 2 * cooled_prev2[x]) / 3;
      end
      nh = nh & 8'hFF;
      cooled_prev2[x] = cooled_prev[x];
      cooled_prev[x]  = fhm_pkg::HeatW'(cooled);
      heat_mem[idx]   = fhm_pkg::HeatW'(nh);
      if (nh < fhm_pkg::RampLow) begin
        p.color = '{red: fhm_pkg::ByteW'(nh * 3), green: '0, blue: '0};
      end else if (nh < fhm_pkg::RampHigh) begin
        p.color = '{red: fhm_pkg::ChanFull,
                    green: fhm_pkg::ByteW'((nh - fhm_pkg::RampLow) * 3), blue: '0};
      end else begin
        p.color = '{red: fhm_pkg::ChanFull, green: fhm_pkg::ChanFull,
                    blue: fhm_pkg::ByteW'((nh - fhm_pkg::RampHigh) * 3)};
      end
      p.pix  = fhm_pkg::PixW'(y * w + x);
      p.heat = fhm_pkg::HeatW'(nh);
      p.done = (x + 1 == w) && (y + 1 == h);
      col_pos = x + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = y + 1;
        if (row_pos >= h) row_pos = 0;
      end
      pending_pixels.push_back(p);
    endfunction

    task report(string what, int got, int want);
      mismatch_count++;
      $display("mismatch %0s: got %0d want %0d (result %0d)", what, got, want,
               pixel_count);
    endtask

    task check_pixel(logic [fhm_pkg::PixW-1:0] pix, fhm_pkg::rgb_t color,
                     logic [fhm_pkg::HeatW-1:0] heat, logic done);
      pixel_item_t w;
      if (pending_pixels.size() == 0) begin
        report("unexpected item", pix, -1);
        return;
      end
      w = pending_pixels.pop_front();
      if (pix !== w.pix) report("pixel_index", pix, w.pix);
      if (color.red !== w.color.red) report("red", color.red, w.color.red);
      if (color.green !== w.color.green) report("green", color.green, w.color.green);
      if (color.blue !== w.color.blue) report("blue", color.blue, w.color.blue);
      if (heat !== w.heat) report("heat_level", heat, w.heat);
      if (done !== w.done) report("frame_done", done, w.done);
      pixel_count++;
      if (w.done) frame_count++;
    endtask
  endclass

  localparam int unsigned TotalCells = 1800;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned Latency    = 4;

  logic clk;
  logic rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [fhm_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [fhm_pkg::CfgW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [fhm_pkg::CoolW-1:0] cool_amount_i;
  logic [fhm_pkg::ByteW-1:0] ignite_roll_i, ignite_boost_i;
  logic out_valid_o, out_ready_i;
  logic [fhm_pkg::PixW-1:0] pixel_index_o;
  logic [fhm_pkg::ByteW-1:0] red_o, green_o, blue_o;
  logic [fhm_pkg::HeatW-1:0] heat_level_o;
  logic frame_done_o;

  fire_pixel_checker sb;
  bit quiet;            // set for the tail of the run: no idling on either side
  int unsigned cells_sent;
  int unsigned cfg_writes;
  int unsigned idle_cycles;

  fire_heat_map_pixel_engine_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cool_amount_i  (cool_amount_i),
    .ignite_roll_i  (ignite_roll_i),
    .ignite_boost_i (ignite_boost_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_index_o  (pixel_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .heat_level_o   (heat_level_o),
    .frame_done_o   (frame_done_o)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: mostly ready, with random stall bursts until the quiet tail
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 7) != 0) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end
    end
  end

  // every accepted pixel item is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel(pixel_index_o, '{red: red_o, green: green_o, blue: blue_o},
                     heat_level_o, frame_done_o);
  end

  // watchdog: too many cycles in a row with no handshake on any channel
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // one config register write, taken at a valid and ready edge
  task automatic write_reg(logic [fhm_pkg::CfgIdxW-1:0] idx,
                           logic [fhm_pkg::CfgW-1:0] val);
    @(negedge clk);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk); while (!(cfg_valid_i && cfg_ready_o));
    sb.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  // one cell item; an optional idle burst comes first
  task automatic send_cell(logic [fhm_pkg::CoolW-1:0] cool,
                           logic [fhm_pkg::ByteW-1:0] roll,
                           logic [fhm_pkg::ByteW-1:0] boost);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i     = 1'b1;
    cool_amount_i  = cool;
    ignite_roll_i  = roll;
    ignite_boost_i = boost;
    do @(posedge clk); while (!(in_valid_i && in_ready_o));
    sb.note_cell(cool, roll, boost);
    cells_sent++;
  endtask

  // random cell content, rolls pulled toward the ignition threshold now and then
  task automatic send_random_cell();
    logic [fhm_pkg::ByteW-1:0] roll;
    roll = ($urandom_range(0, 4) == 0) ? fhm_pkg::ByteW'($urandom_range(146, 153))
                                       : fhm_pkg::ByteW'($urandom_range(0, 255));
    send_cell(fhm_pkg::CoolW'($urandom_range(0, 15)), roll,
              fhm_pkg::ByteW'($urandom_range(0, 255)));
  endtask

  // hold the input, drain every owed pixel, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic set_frame(logic [fhm_pkg::CfgW-1:0] w, logic [fhm_pkg::CfgW-1:0] h);
    wait_idle();
    write_reg(fhm_pkg::CfgFrameWidth, w);
    write_reg(fhm_pkg::CfgFrameHeight, h);
  endtask

  // sizes: zero, one, the maximum, saturating values and plain in-range ones
  function automatic logic [fhm_pkg::CfgW-1:0] pick_size();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return fhm_pkg::CfgW'(1);
      2: return fhm_pkg::CfgW'(fhm_pkg::MaxWidth);
      3: return fhm_pkg::CfgW'($urandom_range(33, 63));
      4: return fhm_pkg::CfgW'($urandom_range(1, 4));
      default: return fhm_pkg::CfgW'($urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    int unsigned phase_len;
    sb          = new();
    quiet       = 1'b0;
    cells_sent  = 0;
    cfg_writes  = 0;
    idle_cycles = 0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = fhm_pkg::CfgFrameWidth;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    cool_amount_i  = '0;
    ignite_roll_i  = '0;
    ignite_boost_i = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // warm-up frame, zero width meaning full width, two rows: fills both line
    // buffers in every column so later size changes never read stale entries
    write_reg(fhm_pkg::CfgFrameWidth, '0);
    write_reg(fhm_pkg::CfgFrameHeight, fhm_pkg::CfgW'(2));
    repeat (2 * fhm_pkg::MaxWidth) send_random_cell();

    // one-cell frame: the heat store entry is reread right after its write
    set_frame(fhm_pkg::CfgW'(1), fhm_pkg::CfgW'(1));
    send_cell(4'd15, 8'd0, 8'd255);
    send_cell(4'd0, 8'd200, 8'd0);
    send_cell(4'd15, 8'd255, 8'd0);
    send_cell(4'd7, 8'd150, 8'd255);
    send_cell(4'd0, 8'd149, 8'd0);
    send_cell(4'd15, 8'd255, 8'd255);
    // one column: line buffers hit back to back, rows two and three averaged
    set_frame(fhm_pkg::CfgW'(1), fhm_pkg::CfgW'(4));
    send_cell(4'd5, 8'd10, 8'd75);
    send_cell(4'd3, 8'd255, 8'd0);
    send_cell(4'd9, 8'd255, 8'd0);
    send_cell(4'd2, 8'd255, 8'd0);
    send_cell(4'd0, 8'd0, 8'd255);
    send_cell(4'd15, 8'd149, 8'd200);
    send_cell(4'd4, 8'd151, 8'd0);
    send_cell(4'd1, 8'd255, 8'd255);
    // saturating sizes, then a size change in the middle of a frame
    set_frame(fhm_pkg::CfgW'(33), fhm_pkg::CfgW'(63));
    send_cell(4'd0, 8'd255, 8'd0);
    send_cell(4'd15, 8'd0, 8'd0);
    send_cell(4'd8, 8'd100, 8'd170);
    set_frame(fhm_pkg::CfgW'(2), '0);
    send_cell(4'd0, 8'd255, 8'd0);
    send_cell(4'd15, 8'd255, 8'd255);
    send_cell(4'd6, 8'd0, 8'd128);

    // random phases: new sizes taken only while idle, cursors left mid-frame
    while (cells_sent < TotalCells) begin
      if (!quiet && $urandom_range(0, 3) != 0) begin
        wait_idle();
        if ($urandom_range(0, 2) != 0) write_reg(fhm_pkg::CfgFrameWidth, pick_size());
        if ($urandom_range(0, 2) != 0) write_reg(fhm_pkg::CfgFrameHeight, pick_size());
      end
      phase_len = $urandom_range(10, 150);
      if (cells_sent > TotalCells * 85 / 100) quiet = 1'b1;
      repeat (phase_len) send_random_cell();
      // sender holds off until every owed pixel is back
      if (!quiet && $urandom_range(0, 2) == 0) wait_idle();
    end

    wait_idle();
    repeat (2 * Latency) @(posedge clk);
    $display("covered %0d cells, %0d pixel items, %0d whole frames, %0d register writes",
             cells_sent, sb.pixel_count, sb.frame_count, cfg_writes);
    $display("sizes from one cell to full and saturating, with mid-frame size changes");
    if (sb.mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fhm_pkg.sv
rtl/core/fhm_heat_ramp.sv
rtl/core/fire_heat_map_pixel_engine_top.sv
tb/tb_fire_heat_map_pixel_engine_top.sv
